[hdl/plu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plu_pkg
// Shared constants, types and codes of the pivot list to permutation unit.
// ----------------------------------------------------------------------------
package plu_pkg;

  localparam int MAX_ORDER  = 32;
  localparam int ORD_W      = 7;
  localparam int ROW_W      = 6;
  localparam int SING_W     = 7;
  localparam int CNT_W      = $clog2(MAX_ORDER + 1);
  localparam int IDX_W      = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int ADDR_W     = IDX_W + 1;
  localparam int RAM_DEPTH  = 2 * MAX_ORDER;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_ORDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INFO_ENABLE  = 2'd1;

  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_CNT_W = 2;

  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] order;
    logic [CNT_W-1:0] loaded;
    logic [CNT_W-1:0] first_zero;
    logic             fault;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } back_state_e;

endpackage

[hdl/plu_pivot_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plu_pivot_if
// Pivot channel: one beat per matrix row.
// ----------------------------------------------------------------------------
interface plu_pivot_if;
  logic       valid;
  logic       ready;
  logic [6:0] pivot_row;
  logic       diag_is_zero;
  logic       last_row;

  modport source (output valid, pivot_row, diag_is_zero, last_row, input ready);
  modport sink   (input valid, pivot_row, diag_is_zero, last_row, output ready);
endinterface

[hdl/plu_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plu_result_if
// Result channel: one beat per permutation matrix row.
// ----------------------------------------------------------------------------
interface plu_result_if;
  logic       valid;
  logic       ready;
  logic [5:0] row_index;
  logic [5:0] one_column;
  logic [6:0] singular_index;
  logic       bad_pivot;
  logic       last_result;

  modport source (output valid, row_index, one_column, singular_index, bad_pivot,
                  last_result, input ready);
  modport sink   (input valid, row_index, one_column, singular_index, bad_pivot,
                  last_result, output ready);
endinterface

[hdl/plu_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plu_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface plu_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [6:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

[hdl/pivot_list_to_permutation_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pivot_list_to_permutation_unit
// Turns the 1-based pivot list of one LU factor into the 0-based column of
// the one in each row of the permutation matrix.
//
// Channels: pivot_i takes one beat per row (pivot, zero-diagonal flag, last
// mark); result_o gives one beat per row once the last-marked beat is in;
// cfg_i writes matrix_order (index 0) and info_enable (index 1), always ready.
// Pivots go into one of two store banks, so a second matrix can load while
// the first is still being walked; pivot_i stalls only while two loaded
// matrices are waiting or in progress.
// Each result reads the store once per interchange (registered read), then
// registers the beat; the walker returns to idle after each matrix and
// picks up the next one there. Loading takes one pivot beat per cycle
// while pivot_i is not stalled.
// Reset: registers return to order 1 with info reporting on, queue empty.
// A stalled receiver holds the current beat and pauses the walker.
// ----------------------------------------------------------------------------
module pivot_list_to_permutation_unit import plu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  plu_pivot_if.sink    pivot_i,
  plu_cfg_if.sink      cfg_i,
  plu_result_if.source result_o
);

  logic              push, pop, full, job_valid;
  job_t              job_in, job_head;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [IDX_W-1:0]  wdata, rdata;

  plu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pivot_i (pivot_i),
    .cfg_i   (cfg_i),
    .full_i  (full),
    .push_o  (push),
    .job_o   (job_in),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata)
  );

  plu_ram #(
    .WIDTH (IDX_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  plu_job_fifo u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (job_valid),
    .head_o  (job_head)
  );

  plu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job_head),
    .pop_o       (pop),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .result_o    (result_o)
  );

endmodule

[hdl/plu_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plu_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module plu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hdl/plu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plu_front
// Register file and pivot loader: checks pivots, fills one store bank and
// hands a finished matrix to the job queue.
// ----------------------------------------------------------------------------
module plu_front import plu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  plu_pivot_if.sink         pivot_i,
  plu_cfg_if.sink           cfg_i,
  input  logic              full_i,
  output logic              push_o,
  output job_t              job_o,
  output logic              we_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [IDX_W-1:0]  wdata_o
);

  logic [ORD_W-1:0] order_q, order_d;
  logic             info_en_q, info_en_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_new;
  logic [CNT_W-1:0] fz_q, fz_d, fz_new;
  logic             fault_q, fault_d, fault_new;
  logic             bank_q, bank_d;
  logic [CNT_W-1:0] n;
  logic             accept, room, prow_ok;

  assign cfg_i.ready   = 1'b1;
  assign pivot_i.ready = !full_i;
  assign accept        = pivot_i.valid && pivot_i.ready;

  always_comb begin
    if (order_q == '0) begin
      n = CNT_W'(1);
    end else if (order_q > ORD_W'(MAX_ORDER)) begin
      n = CNT_W'(MAX_ORDER);
    end else begin
      n = order_q[CNT_W-1:0];
    end
  end

  assign room    = cnt_q < n;
  assign prow_ok = (pivot_i.pivot_row != '0) && (pivot_i.pivot_row <= ORD_W'(n));

  assign we_o    = accept && room;
  assign waddr_o = {bank_q, cnt_q[IDX_W-1:0]};
  assign wdata_o = prow_ok ? IDX_W'(pivot_i.pivot_row - ORD_W'(1)) : cnt_q[IDX_W-1:0];

  assign cnt_new   = room ? cnt_q + CNT_W'(1) : cnt_q;
  assign fault_new = fault_q | (room & !prow_ok);
  assign fz_new    = (room && pivot_i.diag_is_zero && fz_q == '0) ? cnt_q + CNT_W'(1) : fz_q;

  assign push_o           = accept && pivot_i.last_row;
  assign job_o.bank       = bank_q;
  assign job_o.order      = n;
  assign job_o.loaded     = cnt_new;
  assign job_o.first_zero = info_en_q ? fz_new : '0;
  assign job_o.fault      = fault_new;

  always_comb begin
    order_d   = order_q;
    info_en_d = info_en_q;
    cnt_d     = cnt_q;
    fz_d      = fz_q;
    fault_d   = fault_q;
    bank_d    = bank_q;
    if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        CFG_MATRIX_ORDER: order_d   = cfg_i.wr_data;
        CFG_INFO_ENABLE:  info_en_d = cfg_i.wr_data[0];
        default: ;
      endcase
    end
    if (accept) begin
      if (pivot_i.last_row) begin
        cnt_d   = '0;
        fz_d    = '0;
        fault_d = 1'b0;
        bank_d  = !bank_q;
      end else begin
        cnt_d   = cnt_new;
        fz_d    = fz_new;
        fault_d = fault_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q   <= ORD_W'(1);
      info_en_q <= 1'b1;
      cnt_q     <= '0;
      fz_q      <= '0;
      fault_q   <= 1'b0;
      bank_q    <= 1'b0;
    end else begin
      order_q   <= order_d;
      info_en_q <= info_en_d;
      cnt_q     <= cnt_d;
      fz_q      <= fz_d;
      fault_q   <= fault_d;
      bank_q    <= bank_d;
    end
  end

endmodule

[hdl/plu_job_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plu_job_fifo
// Two-entry queue of loaded matrices; an entry is held until its last
// result beat is registered, so it also tracks which store banks are in use.
// ----------------------------------------------------------------------------
module plu_job_fifo import plu_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output job_t head_o
);

  job_t                  entry_q [JOBQ_DEPTH];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [JOBQ_CNT_W-1:0] count_q;

  assign full_o  = count_q == JOBQ_CNT_W'(JOBQ_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + JOBQ_CNT_W'(1);
        2'b01:   count_q <= count_q - JOBQ_CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[hdl/plu_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plu_back
// Permutation walker: for each row, sends the index back through the stored
// interchanges one per cycle and registers the result beat.
// ----------------------------------------------------------------------------
module plu_back import plu_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              pop_o,
  output logic              re_o,
  output logic [ADDR_W-1:0] raddr_o,
  input  logic [IDX_W-1:0]  rdata_i,
  plu_result_if.source      result_o
);

  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, k_q, k_d, kp_q, kp_d, r_q, r_d;
  logic             issue_q, issue_d, pend_q, pend_d;
  logic             out_valid_q, out_valid_d, load_out;
  logic [ROW_W-1:0] row_q, col_q;
  logic [SING_W-1:0] sing_q;
  logic             fault_q, last_q;
  logic [IDX_W-1:0] nm1, p, r_next;

  assign nm1     = IDX_W'(job_i.order - CNT_W'(1));
  assign p       = (CNT_W'(kp_q) < job_i.loaded) ? rdata_i : kp_q;
  assign r_next  = (r_q == kp_q) ? p : ((r_q == p) ? kp_q : r_q);
  assign raddr_o = {job_i.bank, k_q};

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    k_d         = k_q;
    kp_d        = kp_q;
    r_d         = r_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    load_out    = 1'b0;
    re_o        = 1'b0;
    pop_o       = 1'b0;
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          i_d     = '0;
          r_d     = '0;
          k_d     = nm1;
          issue_d = 1'b1;
          pend_d  = 1'b0;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        pend_d = issue_q;
        if (issue_q) begin
          re_o = 1'b1;
          kp_d = k_q;
          if (k_q == '0) begin
            issue_d = 1'b0;
          end else begin
            k_d = k_q - IDX_W'(1);
          end
        end
        if (pend_q) begin
          r_d = r_next;
          if (kp_q == '0) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          if (i_q == nm1) begin
            pop_o   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + IDX_W'(1);
            r_d     = i_q + IDX_W'(1);
            k_d     = nm1;
            issue_d = 1'b1;
            pend_d  = 1'b0;
            state_d = ST_WALK;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q  <= i_d;
    k_q  <= k_d;
    kp_q <= kp_d;
    r_q  <= r_d;
    if (load_out) begin
      row_q   <= ROW_W'(i_q);
      col_q   <= ROW_W'(r_q);
      sing_q  <= SING_W'(job_i.first_zero);
      fault_q <= job_i.fault;
      last_q  <= i_q == nm1;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.row_index      = row_q;
  assign result_o.one_column     = col_q;
  assign result_o.singular_index = sing_q;
  assign result_o.bad_pivot      = fault_q;
  assign result_o.last_result    = last_q;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pivot_list_to_permutation_unit. Pivot beats are
// fed in bursts. A scoreboard keeps its own copy of the pivot store, the
// zero-diagonal tracking and the registers. On every last-marked beat it
// walks each row back through the interchanges and queues the rows of the
// permutation that it expects. Result beats are checked in order, field by
// field, against a receiver that stalls on a changing mask. A short directed
// pass covers the order limits, bad, short and overlong pivot lists and an
// order change part-way through a load. Random phases with new settings
// follow.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [5:0] row_index;
  logic [5:0] one_column;
  logic [6:0] singular_index;
  logic       bad_pivot;
  logic       last_result;
} perm_row_t;

class perm_scoreboard;
  logic [5:0]  ipiv [plu_pkg::MAX_ORDER];
  int          rows_loaded = 0;
  int          first_zero  = 0;
  bit          fault       = 1'b0;
  logic [6:0]  order_reg   = 7'd1;
  bit          info_reg    = 1'b1;
  perm_row_t   owed_rows[$];
  int          mismatches  = 0;

  function int active_order();
    if (order_reg == 7'd0) return 1;
    if (order_reg > plu_pkg::MAX_ORDER) return plu_pkg::MAX_ORDER;
    return int'(order_reg);
  endfunction

  function void write_reg(logic [plu_pkg::CFG_IDX_W-1:0] idx, logic [6:0] value);
    case (idx)
      plu_pkg::CFG_MATRIX_ORDER: order_reg = value;
      plu_pkg::CFG_INFO_ENABLE:  info_reg  = value[0];
      default: ;
    endcase
  endfunction

  // Returns 1 when the beat was stored, 0 when it arrived past the order.
  function bit take_pivot(logic [6:0] prow, logic dz, logic last);
    int        n;
    int        slot;
    int        i;
    int        k;
    int        r;
    int        p;
    bit        stored;
    perm_row_t row;
    n      = active_order();
    stored = 1'b0;
    if (rows_loaded < n) begin
      slot = rows_loaded;
      if (prow >= 1 && prow <= n) begin
        slot = int'(prow) - 1;
      end else begin
        fault = 1'b1;
      end
      ipiv[rows_loaded] = slot[5:0];
      if (dz && first_zero == 0) first_zero = rows_loaded + 1;
      rows_loaded++;
      stored = 1'b1;
    end
    if (!last) return stored;
    for (i = 0; i < n; i++) begin
      r = i;
      for (k = n - 1; k >= 0; k--) begin
        p = (k < rows_loaded) ? int'(ipiv[k]) : k;
        if (r == k) begin
          r = p;
        end else if (r == p) begin
          r = k;
        end
      end
      row.row_index      = i[5:0];
      row.one_column     = r[5:0];
      row.singular_index = info_reg ? first_zero[6:0] : 7'd0;
      row.bad_pivot      = fault;
      row.last_result    = (i + 1 == n);
      owed_rows.push_back(row);
    end
    rows_loaded = 0;
    first_zero  = 0;
    fault       = 1'b0;
    return stored;
  endfunction

  task flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 100) $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task check_row(perm_row_t got);
    perm_row_t want;
    if (owed_rows.size() == 0) begin
      flag_mismatch($sformatf("unexpected beat row %0d col %0d sing %0d bad %0b last %0b",
                              got.row_index, got.one_column, got.singular_index,
                              got.bad_pivot, got.last_result));
      return;
    end
    want = owed_rows.pop_front();
    if (got !== want) begin
      flag_mismatch($sformatf({"row %0d/%0d col %0d/%0d sing %0d/%0d bad %0b/%0b ",
                               "last %0b/%0b (got/expected)"},
                              got.row_index, want.row_index, got.one_column,
                              want.one_column, got.singular_index, want.singular_index,
                              got.bad_pivot, want.bad_pivot, got.last_result,
                              want.last_result));
    end
  endtask
endclass

module tb_top import plu_pkg::*; ;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 2 * MAX_ORDER + 8;
  localparam int RANDOM_ITEMS   = 150;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  plu_pivot_if  pivot_bus ();
  plu_cfg_if    cfg_bus ();
  plu_result_if result_bus ();

  pivot_list_to_permutation_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pivot_i  (pivot_bus),
    .cfg_i    (cfg_bus),
    .result_o (result_bus)
  );

  perm_scoreboard perm_sb;
  int             burst_left  = 0;
  int             max_gap     = 0;
  int             rows_sent   = 0;
  int             quiet_cycles = 0;
  logic [15:0]    stall_mask  = 16'hFFFF;
  logic [3:0]     stall_phase = 4'd0;

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    result_bus.ready <= stall_mask[stall_phase];
    stall_phase      <= stall_phase + 4'd1;
  end

  always @(posedge clk_i) begin
    perm_row_t got;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      got.row_index      = result_bus.row_index;
      got.one_column     = result_bus.one_column;
      got.singular_index = result_bus.singular_index;
      got.bad_pivot      = result_bus.bad_pivot;
      got.last_result    = result_bus.last_result;
      perm_sb.check_row(got);
    end
  end

  always @(posedge clk_i) begin
    if ((pivot_bus.valid && pivot_bus.ready) || (cfg_bus.valid && cfg_bus.ready) ||
        (result_bus.valid && result_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("pivot_list_to_permutation_unit regression: fail");
      $finish;
    end
  end

  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [6:0] value);
    @(negedge clk_i);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.reg_index <= idx;
    cfg_bus.wr_data   <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
    perm_sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic pivot_gap(int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      pivot_bus.valid        <= 1'b0;
      pivot_bus.pivot_row    <= 7'($urandom);
      pivot_bus.diag_is_zero <= 1'($urandom);
      pivot_bus.last_row     <= 1'($urandom);
    end
  endtask

  task automatic send_pivot(logic [6:0] prow, logic dz, logic last);
    if (burst_left == 0) begin
      pivot_gap($urandom_range(max_gap, 0));
      burst_left = $urandom_range(12, 1);
    end
    burst_left--;
    @(negedge clk_i);
    pivot_bus.valid        <= 1'b1;
    pivot_bus.pivot_row    <= prow;
    pivot_bus.diag_is_zero <= dz;
    pivot_bus.last_row     <= last;
    do @(posedge clk_i); while (!pivot_bus.ready);
    if (perm_sb.take_pivot(prow, dz, last)) rows_sent++;
  endtask

  // Drop valid, let every owed row drain, then allow the walker to finish.
  task automatic settle();
    pivot_gap(1);
    while (perm_sb.owed_rows.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_matrix(int n);
    int kind;
    int j;
    int extra;
    int cnt;
    kind = $urandom_range(9, 0);
    case (kind)
      6: begin
        cnt = $urandom_range(n, 1);
        for (j = 0; j < cnt; j++) begin
          send_pivot(7'($urandom_range(n, 1)), $urandom_range(5, 0) == 0, j == cnt - 1);
        end
      end
      7: begin
        extra = $urandom_range(3, 1);
        for (j = 0; j < n + extra; j++) begin
          send_pivot(j < n ? 7'($urandom_range(n, j + 1)) : 7'($urandom),
                     1'($urandom), j == n + extra - 1);
        end
      end
      8: begin
        for (j = 0; j < n; j++) begin
          send_pivot($urandom_range(3, 0) == 0 ? 7'($urandom_range(127, 0))
                                               : 7'($urandom_range(n, 1)),
                     $urandom_range(7, 0) == 0, j == n - 1);
        end
      end
      9: begin
        cnt = $urandom_range(n + 2, 1);
        for (j = 0; j < cnt; j++) begin
          send_pivot(7'($urandom), 1'($urandom), j == cnt - 1);
        end
      end
      default: begin
        for (j = 0; j < n; j++) begin
          send_pivot(kind < 3 ? 7'($urandom_range(n, j + 1)) : 7'($urandom_range(n, 1)),
                     $urandom_range(9, 0) == 0, j == n - 1);
        end
      end
    endcase
  endtask

  function automatic logic [6:0] pick_order();
    int sel;
    sel = $urandom_range(19, 0);
    if (sel < 14) return 7'($urandom_range(8, 1));
    if (sel < 17) return 7'($urandom_range(20, 9));
    if (sel < 19) return 7'($urandom_range(32, 21));
    return $urandom_range(1, 0) ? 7'd0 : 7'($urandom_range(127, 33));
  endfunction

  initial begin
    int          n;
    int          split;
    int          j;
    logic [15:0] mask;
    perm_sb                 = new;
    pivot_bus.valid         = 1'b0;
    pivot_bus.pivot_row     = 7'd0;
    pivot_bus.diag_is_zero  = 1'b0;
    pivot_bus.last_row      = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.reg_index       = CFG_MATRIX_ORDER;
    cfg_bus.wr_data         = 7'd0;
    result_bus.ready        = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: order 1, info on
    stall_mask = 16'hB6DB;
    max_gap    = 2;
    send_pivot(7'd1, 1'b0, 1'b1);
    send_pivot(7'd0, 1'b1, 1'b1);
    settle();
    set_register(CFG_MATRIX_ORDER, 7'd4);
    set_register(CFG_INFO_ENABLE, 7'd1);
    send_pivot(7'd3, 1'b0, 1'b0);
    send_pivot(7'd4, 1'b1, 1'b0);
    send_pivot(7'd3, 1'b0, 1'b0);
    send_pivot(7'd4, 1'b0, 1'b1);
    // short list
    send_pivot(7'd2, 1'b0, 1'b0);
    send_pivot(7'd2, 1'b0, 1'b1);
    // overlong list, tail beats ignored
    send_pivot(7'd1, 1'b0, 1'b0);
    send_pivot(7'd2, 1'b0, 1'b0);
    send_pivot(7'd3, 1'b0, 1'b0);
    send_pivot(7'd4, 1'b0, 1'b0);
    send_pivot(7'd127, 1'b1, 1'b0);
    send_pivot(7'd64, 1'b0, 1'b1);
    settle();
    set_register(CFG_MATRIX_ORDER, 7'd127);
    set_register(CFG_INFO_ENABLE, 7'd0);
    send_pivot(7'd32, 1'b1, 1'b0);
    send_pivot(7'd127, 1'b0, 1'b1);
    settle();
    set_register(CFG_MATRIX_ORDER, 7'd0);
    set_register(CFG_INFO_ENABLE, 7'd1);
    send_pivot(7'd0, 1'b0, 1'b1);
    settle();
    // order cut back part-way through a load
    set_register(CFG_MATRIX_ORDER, 7'd6);
    send_pivot(7'd6, 1'b0, 1'b0);
    send_pivot(7'd5, 1'b1, 1'b0);
    settle();
    set_register(CFG_MATRIX_ORDER, 7'd3);
    send_pivot(7'd3, 1'b0, 1'b0);
    send_pivot(7'd1, 1'b0, 1'b1);

    rows_sent = 0;
    while (rows_sent < RANDOM_ITEMS) begin
      settle();
      set_register(CFG_MATRIX_ORDER, pick_order());
      set_register(CFG_INFO_ENABLE, 7'($urandom_range(1, 0)));
      case ($urandom_range(3, 0))
        0: mask = 16'hFFFF;
        1: mask = 16'($urandom);
        2: mask = 16'($urandom) | 16'($urandom);
        default: mask = 16'($urandom) & 16'($urandom) & 16'($urandom);
      endcase
      stall_mask = (mask == 16'h0) ? 16'h0001 : mask;
      max_gap    = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      n          = perm_sb.active_order();
      if ($urandom_range(7, 0) == 0 && n > 1) begin
        split = $urandom_range(n - 1, 1);
        for (j = 0; j < split; j++) begin
          send_pivot(7'($urandom_range(n, j + 1)), $urandom_range(7, 0) == 0, 1'b0);
        end
        settle();
        set_register(CFG_MATRIX_ORDER, 7'($urandom_range(12, 1)));
        n = perm_sb.active_order();
        for (j = split; j < n; j++) begin
          send_pivot(7'($urandom_range(n, j + 1)), $urandom_range(7, 0) == 0, j == n - 1);
        end
        if (split >= n) send_pivot(7'($urandom_range(n, 1)), 1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(3, 1)) random_matrix(n);
      end
    end

    settle();
    if (perm_sb.mismatches == 0) begin
      $display("pivot_list_to_permutation_unit regression: pass");
    end else begin
      $display("pivot_list_to_permutation_unit regression: fail");
    end
    $finish;
  end
endmodule

[sim.f]
hdl/plu_pkg.sv
hdl/plu_pivot_if.sv
hdl/plu_result_if.sv
hdl/plu_cfg_if.sv
hdl/plu_ram.sv
hdl/plu_front.sv
hdl/plu_job_fifo.sv
hdl/plu_back.sv
hdl/pivot_list_to_permutation_unit.sv
bench/tb_top.sv
